>>> rtl/mmu_pkg.sv
// Shared types and constants for the matrix multiply unit.
// No dependencies; used by every file in rtl/.
package mmu_pkg;

  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int Q_W    = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

>>> rtl/matrix_multiply_unit.sv
// Matrix multiply unit top level: element stores, sequencer, output register.
// Depends on mmu_pkg and mmu_mac.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | command, row_index, col_index, element_value
//   out     | out_valid/out_stall| product_value, out_row, out_col, saturated, last
//   cfg     | cfg_write          | cfg_index, cfg_data
//
// Each result element streams k terms through the single shared multiplier,
// then passes the store read, multiply and accumulate registers and the
// output register. Synchronous active-high reset clears control and sets
// dimensions to 8. in_stall is high for the whole compute; a stalled output
// holds the sequencer.
module matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmu_pkg::DIM_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            command,
  input  logic [mmu_pkg::IDX_W-1:0]             row_index,
  input  logic [mmu_pkg::IDX_W-1:0]             col_index,
  input  logic signed [mmu_pkg::Q_W-1:0]        element_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmu_pkg::Q_W-1:0]        product_value,
  output logic [mmu_pkg::IDX_W-1:0]             out_row,
  output logic [mmu_pkg::IDX_W-1:0]             out_col,
  output logic                                  saturated,
  output logic                                  last
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mmu_pkg::DIM_W-1:0] rows_a;
  logic [mmu_pkg::DIM_W-1:0] inner_size;
  logic [mmu_pkg::DIM_W-1:0] cols_b;

  logic [mmu_pkg::Q_W-1:0] mem_a [DEPTH];
  logic [mmu_pkg::Q_W-1:0] mem_b [DEPTH];
  logic signed [mmu_pkg::Q_W-1:0] rd_a;
  logic signed [mmu_pkg::Q_W-1:0] rd_b;

  mmu_pkg::state_t state, state_next;

  logic [mmu_pkg::IDX_W-1:0] m_lim, k_lim, n_lim;
  logic [mmu_pkg::IDX_W-1:0] r, c, i;

  logic                      in_xfer;
  logic                      load_ok;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      we_a, we_b;
  logic                      start;
  logic                      issue;
  logic                      out_free;
  logic                      out_load;
  logic                      at_last_elem;
  logic [ADDR_W-1:0]         ra_addr, rb_addr;
  mmu_pkg::mac_ctrl_t        ctrl_issue, ctrl_rd;

  logic                              mac_done;
  logic signed [mmu_pkg::Q_W-1:0]    mac_result;
  logic                              mac_sat;

  function automatic logic [mmu_pkg::IDX_W-1:0] dim_lim(input logic [mmu_pkg::DIM_W-1:0] v);
    logic [mmu_pkg::IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > mmu_pkg::DIM_W'(MAX_DIM)) begin
      res = mmu_pkg::IDX_W'(MAX_DIM - 1);
    end else begin
      res = mmu_pkg::IDX_W'(v - 1'b1);
    end
    return res;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= mmu_pkg::DIM_RESET;
      inner_size <= mmu_pkg::DIM_RESET;
      cols_b     <= mmu_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mmu_pkg::CFG_ROWS_A:     rows_a     <= cfg_data;
        mmu_pkg::CFG_INNER_SIZE: inner_size <= cfg_data;
        mmu_pkg::CFG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_xfer = in_valid & ~in_stall;
  assign load_ok = ({1'b0, row_index} < (mmu_pkg::IDX_W+1)'(MAX_DIM)) &&
                   ({1'b0, col_index} < (mmu_pkg::IDX_W+1)'(MAX_DIM));
  assign wr_addr = ADDR_W'(row_index * MAX_DIM + col_index);
  assign we_a    = in_xfer & load_ok & (command == mmu_pkg::CMD_LOAD_A);
  assign we_b    = in_xfer & load_ok & (command == mmu_pkg::CMD_LOAD_B);
  assign start   = in_xfer & (command == mmu_pkg::CMD_COMPUTE);

  assign ra_addr = ADDR_W'(r * MAX_DIM + i);
  assign rb_addr = ADDR_W'(i * MAX_DIM + c);

  // element stores
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= element_value;
    end
    rd_a <= mem_a[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= element_value;
    end
    rd_b <= mem_b[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_rd <= '0;
    end else begin
      ctrl_rd <= ctrl_issue;
    end
  end

  mmu_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl_rd),
    .a      (rd_a),
    .b      (rd_b),
    .done   (mac_done),
    .result (mac_result),
    .sat    (mac_sat)
  );

  assign out_free     = ~out_valid | ~out_stall;
  assign at_last_elem = (r == m_lim) && (c == n_lim);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mmu_pkg::ST_IDLE:  if (start) state_next = mmu_pkg::ST_ISSUE;
      mmu_pkg::ST_ISSUE: if (i == k_lim) state_next = mmu_pkg::ST_WAIT;
      mmu_pkg::ST_WAIT:  if (mac_done) state_next = mmu_pkg::ST_EMIT;
      mmu_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = at_last_elem ? mmu_pkg::ST_IDLE : mmu_pkg::ST_ISSUE;
        end
      end
      default: state_next = mmu_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall         = 1'b1;
    issue            = 1'b0;
    out_load         = 1'b0;
    case (state)
      mmu_pkg::ST_IDLE:  in_stall = 1'b0;
      mmu_pkg::ST_ISSUE: issue    = 1'b1;
      mmu_pkg::ST_WAIT:  ;
      mmu_pkg::ST_EMIT:  out_load = out_free;
      default: ;
    endcase
    ctrl_issue.valid = issue;
    ctrl_issue.first = (i == '0);
    ctrl_issue.last  = (i == k_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (start) begin
      m_lim <= dim_lim(rows_a);
      k_lim <= dim_lim(inner_size);
      n_lim <= dim_lim(cols_b);
      r     <= '0;
      c     <= '0;
      i     <= '0;
    end else if (issue) begin
      i <= (i == k_lim) ? '0 : i + 1'b1;
    end else if (out_load && !at_last_elem) begin
      if (c == n_lim) begin
        c <= '0;
        r <= r + 1'b1;
      end else begin
        c <= c + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      product_value <= mac_result;
      saturated     <= mac_sat;
      out_row       <= r;
      out_col       <= c;
      last          <= at_last_elem;
    end
  end

endmodule

>>> rtl/mmu_mac.sv
// Shared multiply-accumulate unit: registered multiply, 40-bit accumulate,
// Q4.12 truncation and saturation. Depends on mmu_pkg.
module mmu_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  mmu_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [mmu_pkg::Q_W-1:0]      a,
  input  logic signed [mmu_pkg::Q_W-1:0]      b,
  output logic                                done,
  output logic signed [mmu_pkg::Q_W-1:0]      result,
  output logic                                sat
);

  mmu_pkg::mac_ctrl_t                   ctrl_p;
  logic signed [mmu_pkg::PROD_W-1:0]    prod;
  logic signed [mmu_pkg::ACC_W-1:0]     acc;
  logic signed [mmu_pkg::ACC_W-1:0]     prod_ext;
  logic                                 over_hi;
  logic                                 over_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p <= '0;
      done   <= 1'b0;
    end else begin
      ctrl_p <= ctrl;
      done   <= ctrl_p.valid & ctrl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctrl_p.valid) begin
      acc <= ctrl_p.first ? prod_ext : acc + prod_ext;
    end
  end

  assign prod_ext = {{(mmu_pkg::ACC_W-mmu_pkg::PROD_W){prod[mmu_pkg::PROD_W-1]}}, prod};

  // floor(acc / 4096) is acc[39:12]; it fits in Q4.12 when acc[39:27] is all one sign
  assign over_hi = ~acc[mmu_pkg::ACC_W-1] &
                   (|acc[mmu_pkg::ACC_W-2:mmu_pkg::FRAC_W+mmu_pkg::Q_W-1]);
  assign over_lo = acc[mmu_pkg::ACC_W-1] &
                   ~(&acc[mmu_pkg::ACC_W-2:mmu_pkg::FRAC_W+mmu_pkg::Q_W-1]);
  assign sat     = over_hi | over_lo;

  always_comb begin
    if (over_hi) begin
      result = 16'sh7fff;
    end else if (over_lo) begin
      result = -16'sh8000;
    end else begin
      result = acc[mmu_pkg::FRAC_W+mmu_pkg::Q_W-1:mmu_pkg::FRAC_W];
    end
  end

endmodule

>>> rtl/mmu_checker.sv
// Port-level checks for the matrix multiply unit, bound to the top level.
// Depends on mmu_pkg and matrix_multiply_unit.
module mmu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [1:0]                      command,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mmu_pkg::Q_W-1:0]         product_value,
  input logic [mmu_pkg::IDX_W-1:0]       out_row,
  input logic [mmu_pkg::IDX_W-1:0]       out_col,
  input logic                            last
);

  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == mmu_pkg::CMD_COMPUTE) |=> in_stall)
    else $error("input taken right after a compute transfer");

  a_pending_elem_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("input open while product still in progress");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command != mmu_pkg::CMD_COMPUTE && !out_valid)
      |=> !out_valid)
    else $error("result appeared after a load");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(product_value) &&
      $stable(out_row) && $stable(out_col) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (.*);

>>> tb/matrix_multiply_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for matrix_multiply_unit: a directed table, then random loads and
// products over several dimension settings, checked against expected table values
// or an in-bench model. Depends on mmu_pkg and the rtl/ sources.
module matrix_multiply_unit_test;

  localparam int MAX_DIM = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AFTER = 120;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [mmu_pkg::ACC_W-1:0] Q_TOP = 40'sd32767;
  localparam logic signed [mmu_pkg::ACC_W-1:0] Q_BOTTOM = -40'sd32768;

  typedef struct packed {
    logic [mmu_pkg::Q_W-1:0]   value;
    logic [mmu_pkg::IDX_W-1:0] row;
    logic [mmu_pkg::IDX_W-1:0] col;
    logic                      sat;
    logic                      last;
  } product_elem_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [mmu_pkg::IDX_W-1:0] row;
    logic [mmu_pkg::IDX_W-1:0] col;
    logic [mmu_pkg::Q_W-1:0]   val;
    logic                      given;
    logic [mmu_pkg::Q_W-1:0]   exp_val;
    logic                      exp_sat;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [mmu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mmu_pkg::DIM_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] command;
  logic [mmu_pkg::IDX_W-1:0] row_index;
  logic [mmu_pkg::IDX_W-1:0] col_index;
  logic signed [mmu_pkg::Q_W-1:0] element_value;
  logic out_valid;
  logic out_stall;
  logic signed [mmu_pkg::Q_W-1:0] product_value;
  logic [mmu_pkg::IDX_W-1:0] out_row;
  logic [mmu_pkg::IDX_W-1:0] out_col;
  logic saturated;
  logic last;

  logic signed [mmu_pkg::Q_W-1:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [mmu_pkg::Q_W-1:0] b_elems [MAX_DIM*MAX_DIM];
  bit a_loaded [MAX_DIM*MAX_DIM];
  bit b_loaded [MAX_DIM*MAX_DIM];
  logic [mmu_pkg::DIM_W-1:0] dim_rows;
  logic [mmu_pkg::DIM_W-1:0] dim_inner;
  logic [mmu_pkg::DIM_W-1:0] dim_cols;
  product_elem_t pending_products [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  directed_row_t plan [0:22] = '{
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 16'h7FFF, 1'b1},
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1, 16'h7FFF, 1'b1},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd3, 3'd5, 16'h5A5A, 1'b1, 16'h8000, 1'b1},
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h1000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'h1000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 16'h1000, 1'b0},
    '{mmu_pkg::CMD_LOAD_A,  3'd7, 3'd7, 16'h5555, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd7, 3'd7, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
    '{CMD_UNUSED,           3'd5, 3'd2, 16'h1234, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd2, 3'd6, 16'hC3C3, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_A,  3'd0, 3'd0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_LOAD_B,  3'd0, 3'd0, 16'h1000, 1'b0, 16'h0000, 1'b0},
    '{mmu_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 16'h7FFF, 1'b0}
  };

  matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row_index(row_index), .col_index(col_index),
    .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .product_value(product_value), .out_row(out_row), .out_col(out_col),
    .saturated(saturated), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_dim(logic [mmu_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void predict_product();
    int m;
    int k;
    int n;
    logic signed [mmu_pkg::ACC_W-1:0] acc;
    logic signed [mmu_pkg::ACC_W-1:0] q;
    product_elem_t e;
    m = eff_dim(dim_rows);
    k = eff_dim(dim_inner);
    n = eff_dim(dim_cols);
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int i = 0; i < k; i++)
          acc += a_elems[r*MAX_DIM+i] * b_elems[i*MAX_DIM+c];
        q = acc >>> mmu_pkg::FRAC_W;
        e.sat = 1'b0;
        if (q > Q_TOP) begin
          q = Q_TOP;
          e.sat = 1'b1;
        end else if (q < Q_BOTTOM) begin
          q = Q_BOTTOM;
          e.sat = 1'b1;
        end
        e.value = q[mmu_pkg::Q_W-1:0];
        e.row = mmu_pkg::IDX_W'(r);
        e.col = mmu_pkg::IDX_W'(c);
        e.last = (r == m - 1) && (c == n - 1);
        pending_products.push_back(e);
      end
    end
  endfunction

  function automatic void accept_item(logic [1:0] cmd, logic [mmu_pkg::IDX_W-1:0] row,
                                      logic [mmu_pkg::IDX_W-1:0] col,
                                      logic [mmu_pkg::Q_W-1:0] val);
    case (cmd)
      mmu_pkg::CMD_LOAD_A: begin
        a_elems[{row, col}] = val;
        a_loaded[{row, col}] = 1'b1;
      end
      mmu_pkg::CMD_LOAD_B: begin
        b_elems[{row, col}] = val;
        b_loaded[{row, col}] = 1'b1;
      end
      mmu_pkg::CMD_COMPUTE: begin
        predict_product();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [mmu_pkg::Q_W-1:0] random_q412();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return mmu_pkg::Q_W'($urandom);
      default: return mmu_pkg::Q_W'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_item(logic [1:0] cmd, logic [mmu_pkg::IDX_W-1:0] row,
                           logic [mmu_pkg::IDX_W-1:0] col,
                           logic [mmu_pkg::Q_W-1:0] val, bit predict);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    row_index <= row;
    col_index <= col;
    element_value <= val;
    do @(posedge clk); while (in_stall);
    if (predict) accept_item(cmd, row, col, val);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [mmu_pkg::DIM_W-1:0] r, logic [mmu_pkg::DIM_W-1:0] k,
                           logic [mmu_pkg::DIM_W-1:0] n);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= mmu_pkg::CFG_ROWS_A;
    cfg_data <= r;
    @(negedge clk);
    cfg_index <= mmu_pkg::CFG_INNER_SIZE;
    cfg_data <= k;
    @(negedge clk);
    cfg_index <= mmu_pkg::CFG_COLS_B;
    cfg_data <= n;
    @(negedge clk);
    cfg_write <= 1'b0;
    dim_rows = r;
    dim_inner = k;
    dim_cols = n;
  endtask

  task automatic compute_with_operands();
    int m;
    int k;
    int n;
    m = eff_dim(dim_rows);
    k = eff_dim(dim_inner);
    n = eff_dim(dim_cols);
    for (int r = 0; r < m; r++)
      for (int i = 0; i < k; i++)
        if (!a_loaded[r*MAX_DIM+i])
          send_item(mmu_pkg::CMD_LOAD_A, mmu_pkg::IDX_W'(r), mmu_pkg::IDX_W'(i),
                    random_q412(), 1'b1);
    for (int i = 0; i < k; i++)
      for (int c = 0; c < n; c++)
        if (!b_loaded[i*MAX_DIM+c])
          send_item(mmu_pkg::CMD_LOAD_B, mmu_pkg::IDX_W'(i), mmu_pkg::IDX_W'(c),
                    random_q412(), 1'b1);
    send_item(mmu_pkg::CMD_COMPUTE, mmu_pkg::IDX_W'($urandom), mmu_pkg::IDX_W'($urandom),
              mmu_pkg::Q_W'($urandom), 1'b1);
  endtask

  task automatic random_phase(logic [mmu_pkg::DIM_W-1:0] r, logic [mmu_pkg::DIM_W-1:0] k,
                              logic [mmu_pkg::DIM_W-1:0] n, int budget);
    int done_items;
    int pick;
    int rmax;
    int cmax;
    logic [1:0] cmd;
    settle();
    configure(r, k, n);
    done_items = 0;
    while (done_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (pick % 2 == 1) begin
          cmd = mmu_pkg::CMD_LOAD_B;
          rmax = eff_dim(dim_inner) - 1;
          cmax = eff_dim(dim_cols) - 1;
        end else begin
          cmd = mmu_pkg::CMD_LOAD_A;
          rmax = eff_dim(dim_rows) - 1;
          cmax = eff_dim(dim_inner) - 1;
        end
        if ($urandom_range(0, 3) == 0) begin
          rmax = MAX_DIM - 1;
          cmax = MAX_DIM - 1;
        end
        send_item(cmd, mmu_pkg::IDX_W'($urandom_range(0, rmax)),
                  mmu_pkg::IDX_W'($urandom_range(0, cmax)), random_q412(), 1'b1);
        done_items++;
      end else if (pick < 94) begin
        compute_with_operands();
        done_items++;
      end else begin
        send_item(CMD_UNUSED, mmu_pkg::IDX_W'($urandom), mmu_pkg::IDX_W'($urandom),
                  mmu_pkg::Q_W'($urandom), 1'b1);
      end
    end
    compute_with_operands();
  endtask

  always @(posedge clk) begin : compare_products
    product_elem_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer (%0d,%0d) value %h",
                                  out_row, out_col, product_value));
      end else begin
        want = pending_products.pop_front();
        if (product_value !== want.value)
          report_mismatch($sformatf("product_value %h, want %h at (%0d,%0d)",
                                    product_value, want.value, want.row, want.col));
        if (out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated %b, want %b at (%0d,%0d)",
                                    saturated, want.sat, want.row, want.col));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, want %b at (%0d,%0d)",
                                    last, want.last, want.row, want.col));
      end
    end
  end

  initial begin : drive_out_stall
    bit held;
    bit level;
    int len;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        level = 1'b1;
        len = HOLD_CYCLES;
      end else if (quiet) begin
        level = 1'b0;
        len = 1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            level = 1'b0;
            len = $urandom_range(20, 80);
          end
          1: begin
            level = 1'b1;
            len = $urandom_range(1, 14);
          end
          default: begin
            level = 1'b0;
            len = $urandom_range(1, 14);
          end
        endcase
      end
      @(negedge clk);
      out_stall <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = mmu_pkg::CFG_ROWS_A;
    cfg_data = '0;
    in_valid = 1'b0;
    command = mmu_pkg::CMD_LOAD_A;
    row_index = '0;
    col_index = '0;
    element_value = '0;
    dim_rows = mmu_pkg::DIM_RESET;
    dim_inner = mmu_pkg::DIM_RESET;
    dim_cols = mmu_pkg::DIM_RESET;
    foreach (a_elems[i]) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero rows is read as one, giving 1x1x1 products
    configure(4'd0, 4'd1, 4'd1);
    for (int i = 0; i < $size(plan); i++) begin
      send_item(plan[i].cmd, plan[i].row, plan[i].col, plan[i].val, !plan[i].given);
      if (plan[i].given)
        pending_products.push_back('{plan[i].exp_val, 3'd0, 3'd0, plan[i].exp_sat, 1'b1});
    end

    random_phase(4'd2, 4'd3, 4'd4, 14);
    random_phase(4'd8, 4'd8, 4'd8, 10);
    random_phase(4'd15, 4'd9, 4'd12, 6);
    random_phase(4'd1, 4'd8, 4'd1, 16);
    random_phase(4'd3, 4'd1, 4'd5, 16);
    random_phase(4'd0, 4'd0, 4'd0, 16);
    random_phase(4'd8, 4'd1, 4'd8, 14);
    quiet = 1'b1;
    random_phase(4'd4, 4'd4, 4'd4, 24);
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
